// ===== rtl/core/mclf_pkg.sv =====
`default_nettype none

package mclf_pkg;

    localparam int NUM_CH             = 4;
    localparam int CH_BITS            = 2;
    localparam int LVL_W              = 16;
    localparam int DELAY_W            = 16;
    localparam int FACTOR_W           = 8;
    localparam int STEPS_W            = 16;
    localparam int WAIT_W             = 24;
    localparam int LEVEL_BITS_DEFAULT = 16;

    localparam int ADDR_BITS = 3;
    localparam int DATA_W    = 32;

    localparam int FIFO_DEPTH = 8;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_TICK  = 1'b1;

    localparam logic [1:0] MODE_SUCCESSIVE   = 2'd0;
    localparam logic [1:0] MODE_DIRECT       = 2'd1;
    localparam logic [1:0] MODE_SIMULTANEOUS = 2'd2;
    localparam logic [1:0] MODE_SPARE        = 2'd3;

    localparam logic REG_DELAY_FACTOR = 1'b0;
    localparam logic REG_MAX_STEPS    = 1'b1;

    localparam logic [FACTOR_W-1:0] DELAY_FACTOR_RESET = 8'd1;
    localparam logic [STEPS_W-1:0]  MAX_STEPS_RESET    = 16'd1000;

    typedef struct packed {
        logic               cmd;
        logic [1:0]         mode;
        logic [DELAY_W-1:0] step_delay;
        logic [LVL_W-1:0]   target_white;
        logic [LVL_W-1:0]   target_red;
        logic [LVL_W-1:0]   target_green;
        logic [LVL_W-1:0]   target_blue;
    } req_t;

    typedef struct packed {
        logic [CH_BITS-1:0] channel;
        logic [LVL_W-1:0]   level;
        logic               last;
    } res_t;

endpackage

`default_nettype wire

// ===== rtl/core/multi_channel_led_fader.sv =====
`default_nettype none
// four-channel led fader (white, red, green, blue)
// request channel: req_valid / req_stall / req. cmd start loads mode, step
// delay and four targets and performs the first fade action at once; cmd tick
// counts down the wait and performs the next action when it has run out.
// result channel: res_valid / res_stall / res, one level write per transfer,
// last set on the final write caused by a request.
// apb port: delay_factor at byte address 0, max_steps at 4, pready always high.
// queue: all writes of a request enter an 8-entry output queue at the edge
// that accepts it and leave it from the next cycle, one per unstalled cycle.
// throughput: one request per cycle while the queue has room for four writes;
// a request causes zero to four writes, and the queue drains one per unstalled
// cycle, so a stream of four-write requests is paced by req_stall.
// when the receiver stalls, writes wait in the queue and req_stall rises once
// more than four entries are held.
// reset: levels and targets zero, idle, delay_factor 1, max_steps 1000,
// output queue empty.
module multi_channel_led_fader #(
    parameter int LEVEL_BITS = mclf_pkg::LEVEL_BITS_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [mclf_pkg::ADDR_BITS-1:0] paddr,
    input  logic [mclf_pkg::DATA_W-1:0]    pwdata,
    output logic [mclf_pkg::DATA_W-1:0]    prdata,
    output logic                           pready,
    input  logic                           req_valid,
    output logic                           req_stall,
    input  mclf_pkg::req_t                 req,
    output logic                           res_valid,
    input  logic                           res_stall,
    output mclf_pkg::res_t                 res
);
    import mclf_pkg::*;

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = PTR_W + 1;
    localparam int NUM_W = $clog2(NUM_CH) + 1;

    logic [FACTOR_W-1:0] delay_factor_reg;
    logic [STEPS_W-1:0]  max_steps_reg;

    logic [LEVEL_BITS-1:0] cur_reg [NUM_CH];
    logic [LEVEL_BITS-1:0] cur_next [NUM_CH];
    logic [LEVEL_BITS-1:0] tgt_reg [NUM_CH];
    logic [LEVEL_BITS-1:0] tgt_next [NUM_CH];
    logic [1:0]            mode_reg, mode_next;
    logic [CH_BITS-1:0]    active_reg, active_next;
    logic [WAIT_W-1:0]     wait_reg, wait_next;
    logic [STEPS_W-1:0]    steps_reg, steps_next;
    logic [DELAY_W-1:0]    held_reg, held_next;
    logic                  fading_reg, fading_next;

    res_t             fifo_mem [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg, count_next;

    logic                  accept, start, act, pop;
    logic [LEVEL_BITS-1:0] req_tgt [NUM_CH];
    logic [LEVEL_BITS-1:0] tgt_eff [NUM_CH];
    logic [LEVEL_BITS-1:0] stepped [NUM_CH];
    logic [LEVEL_BITS-1:0] lv [NUM_CH];
    logic [NUM_CH-1:0]     neq, em;
    logic [1:0]            mode_eff;
    logic [CH_BITS-1:0]    active_eff, first_ch, end_ch;
    logic [STEPS_W-1:0]    steps_eff;
    logic [DELAY_W-1:0]    held_eff;
    logic [WAIT_W-1:0]     prod;
    logic                  found, do_snap;
    res_t                  slot [NUM_CH];
    logic [NUM_W-1:0]      n_res, n_push;

    // configuration port
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_factor_reg <= DELAY_FACTOR_RESET;
            max_steps_reg    <= MAX_STEPS_RESET;
        end
        else if (psel && penable && pwrite && pready)
        begin
            unique case (paddr[ADDR_BITS-1])
                REG_DELAY_FACTOR: delay_factor_reg <= pwdata[FACTOR_W-1:0];
                REG_MAX_STEPS:    max_steps_reg    <= pwdata[STEPS_W-1:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[ADDR_BITS-1])
            REG_DELAY_FACTOR: prdata = DATA_W'(delay_factor_reg);
            REG_MAX_STEPS:    prdata = DATA_W'(max_steps_reg);
        endcase
    end

    // request handshake
    assign req_stall = count_reg > CNT_W'(FIFO_DEPTH - NUM_CH);
    assign accept    = req_valid && !req_stall;
    assign start     = req.cmd == CMD_START;
    assign act       = accept && (start || (fading_reg && wait_reg == '0));

    assign req_tgt[0] = req.target_white[LEVEL_BITS-1:0];
    assign req_tgt[1] = req.target_red[LEVEL_BITS-1:0];
    assign req_tgt[2] = req.target_green[LEVEL_BITS-1:0];
    assign req_tgt[3] = req.target_blue[LEVEL_BITS-1:0];

    // values seen by the action: a start request overrides the stored fade
    assign mode_eff   = start ? req.mode : mode_reg;
    assign active_eff = start ? '0 : active_reg;
    assign steps_eff  = start ? '0 : steps_reg;
    assign held_eff   = start ? req.step_delay : held_reg;
    assign prod       = WAIT_W'(held_eff) * WAIT_W'(delay_factor_reg);

    always_comb
    begin
        for (int c = 0; c < NUM_CH; c++)
        begin
            tgt_eff[c] = start ? req_tgt[c] : tgt_reg[c];
            neq[c]     = cur_reg[c] != tgt_eff[c];
            stepped[c] = (cur_reg[c] < tgt_eff[c]) ? cur_reg[c] + LEVEL_BITS'(1)
                                                   : cur_reg[c] - LEVEL_BITS'(1);
        end
    end

    // first unequal channel at or after the active one
    always_comb
    begin
        found    = 1'b0;
        first_ch = '0;
        for (int c = NUM_CH - 1; c >= 0; c--)
        begin
            if (CH_BITS'(c) >= active_eff && neq[c])
            begin
                found    = 1'b1;
                first_ch = CH_BITS'(c);
            end
        end
        end_ch = found ? first_ch : CH_BITS'(NUM_CH - 1);
    end

    // fade state update and level writes
    always_comb
    begin
        cur_next    = cur_reg;
        tgt_next    = tgt_reg;
        mode_next   = mode_reg;
        active_next = active_reg;
        wait_next   = wait_reg;
        steps_next  = steps_reg;
        held_next   = held_reg;
        fading_next = fading_reg;
        em          = '0;
        lv          = cur_reg;
        do_snap     = 1'b0;

        if (accept && start)
        begin
            mode_next   = req.mode;
            held_next   = req.step_delay;
            tgt_next    = req_tgt;
            active_next = '0;
            wait_next   = '0;
            steps_next  = '0;
            fading_next = 1'b1;
        end
        else if (accept && fading_reg && wait_reg != '0)
        begin
            wait_next = wait_reg - WAIT_W'(1);
        end

        if (act)
        begin
            unique case (mode_eff)
                MODE_SUCCESSIVE:
                begin
                    for (int c = 0; c < NUM_CH; c++)
                        em[c] = CH_BITS'(c) >= active_eff && CH_BITS'(c) <= end_ch;
                    if (found)
                    begin
                        cur_next[first_ch] = stepped[first_ch];
                        active_next        = first_ch;
                        wait_next          = WAIT_W'(held_eff);
                    end
                    else
                    begin
                        active_next = CH_BITS'(NUM_CH - 1);
                        fading_next = 1'b0;
                    end
                end
                MODE_SIMULTANEOUS:
                begin
                    if (steps_eff >= max_steps_reg)
                        do_snap = 1'b1;
                    else
                    begin
                        steps_next = steps_eff + STEPS_W'(1);
                        if (neq != '0)
                        begin
                            em        = neq;
                            lv        = stepped;
                            wait_next = prod;
                            for (int c = 0; c < NUM_CH; c++)
                                if (neq[c])
                                    cur_next[c] = stepped[c];
                        end
                        else
                            do_snap = 1'b1;
                    end
                end
                default: do_snap = 1'b1;
            endcase

            if (do_snap)
            begin
                em          = '1;
                lv          = tgt_eff;
                cur_next    = tgt_eff;
                fading_next = 1'b0;
            end
        end
    end

    // pack the writes in channel order, flag the final one
    always_comb
    begin
        n_res = '0;
        for (int k = 0; k < NUM_CH; k++)
            slot[k] = '0;
        for (int c = 0; c < NUM_CH; c++)
        begin
            if (em[c])
            begin
                slot[n_res[NUM_W-2:0]].channel = CH_BITS'(c);
                slot[n_res[NUM_W-2:0]].level   = LVL_W'(lv[c]);
                slot[n_res[NUM_W-2:0]].last    = 1'b0;
                n_res = n_res + NUM_W'(1);
            end
        end
        if (n_res != '0)
            slot[n_res[NUM_W-2:0] - 1'b1].last = 1'b1;
        n_push = act ? n_res : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < NUM_CH; c++)
            begin
                cur_reg[c] <= '0;
                tgt_reg[c] <= '0;
            end
            mode_reg   <= MODE_SUCCESSIVE;
            active_reg <= '0;
            wait_reg   <= '0;
            steps_reg  <= '0;
            held_reg   <= '0;
            fading_reg <= 1'b0;
        end
        else
        begin
            cur_reg    <= cur_next;
            tgt_reg    <= tgt_next;
            mode_reg   <= mode_next;
            active_reg <= active_next;
            wait_reg   <= wait_next;
            steps_reg  <= steps_next;
            held_reg   <= held_next;
            fading_reg <= fading_next;
        end
    end

    // output queue
    assign res_valid  = count_reg != '0;
    assign res        = fifo_mem[rd_ptr_reg];
    assign pop        = res_valid && !res_stall;
    assign count_next = count_reg + CNT_W'(n_push) - CNT_W'(pop);

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < NUM_CH; k++)
            if (NUM_W'(k) < n_push)
                fifo_mem[wr_ptr_reg + PTR_W'(k)] <= slot[k];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + PTR_W'(n_push);
            rd_ptr_reg <= rd_ptr_reg + PTR_W'(pop);
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// ===== tb/fader_checker.sv =====
module fader_checker #(
    parameter int LEVEL_BITS = mclf_pkg::LEVEL_BITS_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic                           pready,
    input  logic [mclf_pkg::ADDR_BITS-1:0] paddr,
    input  logic [mclf_pkg::DATA_W-1:0]    pwdata,
    input  logic                           req_valid,
    input  logic                           req_stall,
    input  mclf_pkg::req_t                 req,
    input  logic                           res_valid,
    input  logic                           res_stall,
    input  mclf_pkg::res_t                 res,
    output int                             mismatches,
    output int                             outstanding
);
    import mclf_pkg::*;

    localparam logic [23:0] WAIT_SAT = 24'hFF_FFFF;

    logic [LVL_W-1:0]    cur_lvl [NUM_CH];
    logic [LVL_W-1:0]    tgt_lvl [NUM_CH];
    logic [1:0]          fade_mode_q;
    logic [CH_BITS-1:0]  act_ch;
    logic [WAIT_W-1:0]   wait_cnt;
    logic [STEPS_W-1:0]  steps_cnt;
    logic [DELAY_W-1:0]  delay_q;
    logic                fading_q;
    logic [FACTOR_W-1:0] factor_q;
    logic [STEPS_W-1:0]  limit_q;

    res_t new_writes[$];
    res_t expected_writes[$];

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        mismatches++;
    endtask

    function automatic logic [LVL_W-1:0] step_toward(input logic [LVL_W-1:0] cur,
                                                     input logic [LVL_W-1:0] tgt);
        return (cur < tgt) ? cur + 1'b1 : cur - 1'b1;
    endfunction

    task automatic add_write(input int ch, input logic [LVL_W-1:0] lvl);
        res_t w;
        w.channel = ch[CH_BITS-1:0];
        w.level = lvl;
        w.last = 1'b0;
        new_writes.push_back(w);
    endtask

    task automatic snap_all();
        for (int c = 0; c < NUM_CH; c++)
        begin
            add_write(c, tgt_lvl[c]);
            cur_lvl[c] = tgt_lvl[c];
        end
        fading_q = 1'b0;
    endtask

    task automatic successive_action();
        bit done;
        int c;
        done = 1'b0;
        while (!done)
        begin
            c = act_ch;
            if (cur_lvl[c] == tgt_lvl[c])
            begin
                add_write(c, tgt_lvl[c]);
                if (c == NUM_CH - 1)
                begin
                    fading_q = 1'b0;
                    done = 1'b1;
                end
                else
                    act_ch = act_ch + 1'b1;
            end
            else
            begin
                add_write(c, cur_lvl[c]);
                cur_lvl[c] = step_toward(cur_lvl[c], tgt_lvl[c]);
                wait_cnt = WAIT_W'(delay_q);
                done = 1'b1;
            end
        end
    endtask

    task automatic simultaneous_action();
        bit changed;
        logic [31:0] prod;
        changed = 1'b0;
        if (steps_cnt >= limit_q)
            snap_all();
        else
        begin
            for (int c = 0; c < NUM_CH; c++)
            begin
                if (cur_lvl[c] != tgt_lvl[c])
                begin
                    cur_lvl[c] = step_toward(cur_lvl[c], tgt_lvl[c]);
                    add_write(c, cur_lvl[c]);
                    changed = 1'b1;
                end
            end
            steps_cnt = steps_cnt + 1'b1;
            if (changed)
            begin
                prod = 32'(delay_q) * 32'(factor_q);
                wait_cnt = (prod > 32'(WAIT_SAT)) ? WAIT_SAT : prod[WAIT_W-1:0];
            end
            else
                snap_all();
        end
    endtask

    task automatic fade_action();
        case (fade_mode_q)
            MODE_SUCCESSIVE:   successive_action();
            MODE_SIMULTANEOUS: simultaneous_action();
            default:           snap_all();
        endcase
    endtask

    task automatic predict_writes(input req_t r);
        logic [LVL_W-1:0] lmask;
        res_t w;
        lmask = LVL_W'((32'd1 << LEVEL_BITS) - 1);
        new_writes.delete();
        if (r.cmd == CMD_START)
        begin
            fade_mode_q = r.mode;
            delay_q = r.step_delay;
            tgt_lvl[0] = r.target_white & lmask;
            tgt_lvl[1] = r.target_red & lmask;
            tgt_lvl[2] = r.target_green & lmask;
            tgt_lvl[3] = r.target_blue & lmask;
            act_ch = '0;
            wait_cnt = '0;
            steps_cnt = '0;
            fading_q = 1'b1;
            fade_action();
        end
        else if (fading_q)
        begin
            if (wait_cnt != 0)
                wait_cnt = wait_cnt - 1'b1;
            else
                fade_action();
        end
        if (new_writes.size() > 0)
        begin
            w = new_writes[new_writes.size() - 1];
            w.last = 1'b1;
            new_writes[new_writes.size() - 1] = w;
        end
        foreach (new_writes[i])
            expected_writes.push_back(new_writes[i]);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        res_t exp_w;
        if (!rst_n)
        begin
            for (int c = 0; c < NUM_CH; c++)
            begin
                cur_lvl[c] = '0;
                tgt_lvl[c] = '0;
            end
            fade_mode_q = MODE_SUCCESSIVE;
            act_ch = '0;
            wait_cnt = '0;
            steps_cnt = '0;
            delay_q = '0;
            fading_q = 1'b0;
            factor_q = DELAY_FACTOR_RESET;
            limit_q = MAX_STEPS_RESET;
            expected_writes.delete();
            mismatches = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[2] == REG_MAX_STEPS)
                    limit_q = pwdata[STEPS_W-1:0];
                else
                    factor_q = pwdata[FACTOR_W-1:0];
            end
            if (res_valid && !res_stall)
            begin
                if (expected_writes.size() == 0)
                    report_mismatch($sformatf("unexpected write ch %0d level %0d",
                                              res.channel, res.level));
                else
                begin
                    exp_w = expected_writes.pop_front();
                    if (res.channel != exp_w.channel)
                        report_mismatch($sformatf("channel got %0d want %0d",
                                                  res.channel, exp_w.channel));
                    if (res.level != exp_w.level)
                        report_mismatch($sformatf("level got %0d want %0d (ch %0d)",
                                                  res.level, exp_w.level, exp_w.channel));
                    if (res.last != exp_w.last)
                        report_mismatch($sformatf("last got %0d want %0d (ch %0d)",
                                                  res.last, exp_w.last, exp_w.channel));
                end
            end
            if (req_valid && !req_stall)
                predict_writes(req);
        end
        outstanding = expected_writes.size();
    end

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
    import mclf_pkg::*;

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_BITS-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              req_valid;
    logic              req_stall;
    req_t              req;
    logic              res_valid;
    logic              res_stall;
    res_t              res;

    int mismatches;
    int outstanding;

    bit quiet;
    bit hold_ask;
    int cur_factor;
    int base_lvl [NUM_CH];

    int phase_factor [6] = '{1, 255, 1, 0, 7, 1};
    int phase_limit  [6] = '{1000, 65535, 1, 3, 0, 1000};

    multi_channel_led_fader uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

    fader_checker chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .pready      (pready),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .req         (req),
        .res_valid   (res_valid),
        .res_stall   (res_stall),
        .res         (res),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    initial
    begin
        #24_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // receiver side: random stall bursts, one long hold on request
    initial
    begin
        res_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_ask)
            begin
                res_stall <= 1'b1;
                repeat (80) @(posedge clk);
                res_stall <= 1'b0;
                hold_ask <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 7) == 0)
            begin
                res_stall <= 1'b1;
                repeat ($urandom_range(1, 14)) @(posedge clk);
                res_stall <= 1'b0;
            end
        end
    end

    function automatic req_t make_start(input logic [1:0] mode, input int delay,
                                        input int w, input int r, input int g,
                                        input int b);
        req_t q;
        q.cmd = CMD_START;
        q.mode = mode;
        q.step_delay = delay[DELAY_W-1:0];
        q.target_white = w[LVL_W-1:0];
        q.target_red = r[LVL_W-1:0];
        q.target_green = g[LVL_W-1:0];
        q.target_blue = b[LVL_W-1:0];
        return q;
    endfunction

    function automatic req_t make_tick();
        req_t q;
        q = req_t'({$urandom, $urandom, $urandom});
        q.cmd = CMD_TICK;
        return q;
    endfunction

    task automatic drive_req(input req_t r, input bit may_idle);
        if (may_idle && !quiet && $urandom_range(0, 3) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        req <= r;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (req_stall);
    endtask

    task automatic send_ticks(input int n);
        repeat (n) drive_req(make_tick(), 1'b1);
    endtask

    task automatic wait_idle();
        req_valid <= 1'b0;
        @(negedge clk);
        while (outstanding != 0) @(negedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic cfg_write(input logic reg_index, input int value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {reg_index, 2'b00};
        pwdata <= DATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    function automatic int near_level(input int b);
        int v;
        v = b + $urandom_range(0, 6) - 3;
        if (v < 0)
            v = 0;
        if (v > 65535)
            v = 65535;
        return v;
    endfunction

    // one start with random content, then enough ticks to finish it most of the time
    task automatic run_sequence(output int n_items);
        logic [1:0] mode;
        int delay;
        int tgt [NUM_CH];
        int sumdiff;
        int per_step;
        int budget;
        bit far_delay;
        bit is_direct;
        case ($urandom_range(0, 9))
            0, 1, 2:    mode = MODE_SUCCESSIVE;
            3, 4:       mode = MODE_DIRECT;
            5, 6, 7, 8: mode = MODE_SIMULTANEOUS;
            default:    mode = MODE_SPARE;
        endcase
        is_direct = (mode == MODE_DIRECT) || (mode == MODE_SPARE);
        far_delay = ($urandom_range(0, 15) == 0);
        delay = far_delay ? $urandom_range(0, 65535) : $urandom_range(0, 2);
        sumdiff = 0;
        for (int c = 0; c < NUM_CH; c++)
        begin
            if (is_direct && $urandom_range(0, 1) == 0)
                tgt[c] = $urandom_range(0, 65535);
            else
                tgt[c] = near_level(base_lvl[c]);
            sumdiff += (tgt[c] > base_lvl[c]) ? tgt[c] - base_lvl[c] : base_lvl[c] - tgt[c];
        end
        drive_req(make_start(mode, delay, tgt[0], tgt[1], tgt[2], tgt[3]), 1'b1);
        per_step = (mode == MODE_SIMULTANEOUS) ? delay * cur_factor : delay;
        budget = (sumdiff + 2) * (per_step + 1) + 4;
        if (budget > 32)
            budget = 32;
        if (far_delay)
            budget = $urandom_range(0, 3);
        if (is_direct)
            budget = $urandom_range(0, 2);
        if ($urandom_range(0, 5) == 0)
            budget = $urandom_range(0, budget);
        send_ticks(budget);
        for (int c = 0; c < NUM_CH; c++)
            base_lvl[c] = tgt[c];
        n_items = 1 + budget;
    endtask

    initial
    begin
        int n;
        int phase_items;
        int drain;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        req_valid = 1'b0;
        req = '0;
        quiet = 1'b0;
        hold_ask = 1'b0;
        cur_factor = 1;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part at reset configuration
        drive_req(make_start(MODE_DIRECT, 65535, 65535, 65535, 65535, 65535), 1'b0);
        drive_req(make_start(MODE_SPARE, 0, 0, 16'h5555, 16'hAAAA, 65535), 1'b0);
        drive_req(make_start(MODE_DIRECT, 0, 0, 0, 0, 0), 1'b0);
        drive_req(make_tick(), 1'b0);
        drive_req(make_start(MODE_SUCCESSIVE, 0, 1, 0, 0, 1), 1'b0);
        send_ticks(3);
        // slow successive fade dropped by a simultaneous start
        drive_req(make_start(MODE_SUCCESSIVE, 65535, 65535, 65535, 65535, 65535), 1'b0);
        send_ticks(1);
        drive_req(make_start(MODE_SIMULTANEOUS, 1, 0, 2, 0, 0), 1'b0);
        send_ticks(6);
        wait_idle();

        for (int c = 0; c < NUM_CH; c++)
            base_lvl[c] = 0;
        base_lvl[1] = 2;

        for (int p = 0; p < 6; p++)
        begin
            wait_idle();
            if (p == 5)
                quiet <= 1'b1;
            cfg_write(REG_DELAY_FACTOR, phase_factor[p]);
            cfg_write(REG_MAX_STEPS, phase_limit[p]);
            cur_factor = phase_factor[p];
            phase_items = 0;
            if (p == 2)
            begin
                // step limit of one lets far targets through quickly
                drive_req(make_start(MODE_SIMULTANEOUS, 0, 65535, 0, 65535, 0), 1'b1);
                send_ticks(3);
                drive_req(make_start(MODE_DIRECT, 0, 0, 0, 0, 0), 1'b1);
                for (int c = 0; c < NUM_CH; c++)
                    base_lvl[c] = 0;
            end
            while (phase_items < 28)
            begin
                run_sequence(n);
                phase_items += n;
                if (p == 0 && !hold_ask && phase_items >= 15 && phase_items < 15 + n)
                begin
                    // receiver holds off while direct starts keep coming
                    hold_ask <= 1'b1;
                    for (int k = 0; k < 12; k++)
                    begin
                        for (int c = 0; c < NUM_CH; c++)
                            base_lvl[c] = $urandom_range(0, 65535);
                        drive_req(make_start(MODE_DIRECT, $urandom_range(0, 65535),
                                             base_lvl[0], base_lvl[1], base_lvl[2],
                                             base_lvl[3]), 1'b0);
                    end
                    phase_items += 12;
                    wait_idle();
                end
            end
        end

        req_valid <= 1'b0;
        drain = 0;
        while (outstanding != 0 && drain < 20000)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (20) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("RESULT: OK");
        else
        begin
            if (outstanding != 0)
                $display("%0d expected writes never arrived", outstanding);
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
